// ===== hw/rtl/bcvs_pkg.sv =====
// ----------------------------------------------------------------------------
// bcvs_pkg: shared types and constants of the valve sequencer
// Mode, fault and request codes, register indexes, and the bundles passed
// between the top level and the step logic.
// ----------------------------------------------------------------------------
`default_nettype none

package bcvs_pkg;

  // Field widths, position range and command saturation
  localparam int unsigned POS_W          = 14;
  localparam int unsigned TICK_W         = 16;
  localparam int unsigned REM_W          = 17;
  localparam int unsigned BL_W           = 13;
  localparam int unsigned POS_FULL_SCALE = 10000;
  localparam int unsigned CMD_MAX        = 16383;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register reset values
  localparam logic [BL_W-1:0]   BACKLASH_RST   = BL_W'(100);
  localparam logic [POS_W-1:0]  MIN_MOVE_RST   = POS_W'(100);
  localparam logic [POS_W-1:0]  IN_POS_RST     = POS_W'(50);
  localparam logic [TICK_W-1:0] MOVE_TIME_RST  = TICK_W'(10000);
  localparam logic [TICK_W-1:0] TRANS_TIME_RST = TICK_W'(8000);
  localparam logic [REM_W-1:0]  REM_RST        = REM_W'(2 * 10000);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OVERSHOOT_STEP   = 3'd0,
    REG_MINIMAL_MOVE     = 3'd1,
    REG_IN_POSITION      = 3'd2,
    REG_MOVE_TIME_TICKS  = 3'd3,
    REG_TRANSITION_TICKS = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    REQ_DEMAND = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    MODE_ON_TARGET = 2'd0,
    MODE_TO_COMP   = 2'd1,
    MODE_TO_TARGET = 2'd2,
    MODE_FAULTED   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    FAULT_NONE    = 2'd0,
    FAULT_TIMEOUT = 2'd1,
    FAULT_DRIFT   = 2'd2,
    FAULT_RSVD    = 2'd3
  } fault_e;

  typedef struct packed {
    logic [BL_W-1:0]   overshoot_step;
    logic [POS_W-1:0]  minimal_move;
    logic [POS_W-1:0]  in_position;
    logic [TICK_W-1:0] move_time_ticks;
    logic [TICK_W-1:0] transition_ticks;
  } cfg_t;

  typedef struct packed {
    mode_e             mode;
    logic [POS_W-1:0]  last_setpoint;
    logic [POS_W-1:0]  comp_setpoint;
    logic [REM_W-1:0]  remaining_ticks;
  } state_t;

  typedef struct packed {
    mode_e            mode_now;
    fault_e           fault_code;
    logic [POS_W-1:0] command;
    logic             command_valid;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bcvs_step.sv =====
// ----------------------------------------------------------------------------
// bcvs_step: next-state and result logic for one item
// Works out the new sequencer state and the optional result for one demand,
// sample or tick, from the current state and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bcvs_step
  import bcvs_pkg::*;
#(
  parameter int unsigned FULL_SCALE_POS = POS_FULL_SCALE
) (
  input  var cfg_t             cfg_i,
  input  var state_t           state_i,
  input  var logic [1:0]       req_type_i,
  input  var logic [POS_W-1:0] demand_i,
  input  var logic [POS_W-1:0] meas_pos_i,
  output var state_t           state_o,
  output var logic             has_result_o,
  output var result_t          result_o
);

  localparam logic [POS_W:0] FULL_SCALE = (POS_W + 1)'(FULL_SCALE_POS);
  localparam logic [POS_W:0] SAT_TOP    = (POS_W + 1)'(CMD_MAX);

  logic [POS_W-1:0] last;
  logic [POS_W:0]   bl_ext;
  logic             dem_below;
  logic [POS_W-1:0] dem_diff;
  logic [POS_W:0]   last_plus_bl;
  logic [POS_W:0]   dem_plus_bl;
  logic [POS_W-1:0] comp_new;
  logic [POS_W-1:0] diff_comp;
  logic [POS_W-1:0] diff_last;
  logic             near_comp;
  logic             near_last;
  logic             transition;
  logic             timed_out;

  assign last   = state_i.last_setpoint;
  assign bl_ext = (POS_W + 1)'(cfg_i.overshoot_step);

  // Distance of the new demand from the last setpoint
  assign dem_below = demand_i < last;
  assign dem_diff  = dem_below ? last - demand_i : demand_i - last;

  assign last_plus_bl = {1'b0, last} + bl_ext;
  assign dem_plus_bl  = {1'b0, demand_i} + bl_ext;

  // Compensated setpoint: overshoot past the demand, flipped near the range ends
  always_comb begin
    if (dem_below) begin
      if ({1'b0, demand_i} < bl_ext) begin
        comp_new = (last_plus_bl > SAT_TOP) ? SAT_TOP[POS_W-1:0] : last_plus_bl[POS_W-1:0];
      end else begin
        comp_new = demand_i - bl_ext[POS_W-1:0];
      end
    end else begin
      if (dem_plus_bl > FULL_SCALE) begin
        comp_new = ({1'b0, last} < bl_ext) ? '0 : last - bl_ext[POS_W-1:0];
      end else begin
        comp_new = (dem_plus_bl > SAT_TOP) ? SAT_TOP[POS_W-1:0] : dem_plus_bl[POS_W-1:0];
      end
    end
  end

  // Band checks for a position sample
  assign diff_comp = (meas_pos_i < state_i.comp_setpoint)
                     ? state_i.comp_setpoint - meas_pos_i
                     : meas_pos_i - state_i.comp_setpoint;
  assign diff_last = (meas_pos_i < last) ? last - meas_pos_i
                                         : meas_pos_i - last;
  assign near_comp  = diff_comp < cfg_i.in_position;
  assign near_last  = diff_last < cfg_i.in_position;
  assign transition = state_i.remaining_ticks < REM_W'(cfg_i.transition_ticks);
  assign timed_out  = state_i.remaining_ticks == '0;

  // Dispatch on request kind
  always_comb begin
    state_o      = state_i;
    has_result_o = 1'b0;
    result_o     = '{mode_now: state_i.mode, fault_code: FAULT_NONE,
                     command: '0, command_valid: 1'b0};
    case (req_type_i)
      REQ_DEMAND: begin
        if (demand_i != last) begin
          if (dem_diff > cfg_i.minimal_move) begin
            state_o.mode = MODE_TO_TARGET;
          end else begin
            state_o.mode          = MODE_TO_COMP;
            state_o.comp_setpoint = comp_new;
          end
          state_o.last_setpoint   = demand_i;
          state_o.remaining_ticks = REM_W'(cfg_i.move_time_ticks);
        end
      end
      REQ_TICK: begin
        if (!timed_out) begin
          state_o.remaining_ticks = state_i.remaining_ticks - REM_W'(1);
        end
      end
      REQ_SAMPLE: begin
        has_result_o = 1'b1;
        unique case (state_i.mode)
          MODE_TO_COMP: begin
            if (near_comp && transition) begin
              state_o.mode            = MODE_TO_TARGET;
              state_o.remaining_ticks = REM_W'(cfg_i.move_time_ticks);
              result_o.command_valid  = 1'b1;
              result_o.command        = last;
            end else if (timed_out) begin
              state_o.mode        = MODE_FAULTED;
              result_o.fault_code = FAULT_TIMEOUT;
            end else begin
              result_o.command_valid = 1'b1;
              result_o.command       = state_i.comp_setpoint;
            end
          end
          MODE_TO_TARGET: begin
            if (near_last && transition) begin
              state_o.mode = MODE_ON_TARGET;
            end else if (timed_out) begin
              state_o.mode        = MODE_FAULTED;
              result_o.fault_code = FAULT_TIMEOUT;
            end else begin
              result_o.command_valid = 1'b1;
              result_o.command       = last;
            end
          end
          MODE_ON_TARGET: begin
            if (!near_last) begin
              state_o.mode        = MODE_FAULTED;
              result_o.fault_code = FAULT_DRIFT;
            end
          end
          default: begin
          end
        endcase
        result_o.mode_now = state_o.mode;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/backlash_compensated_valve_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// backlash_compensated_valve_sequencer_core: valve setpoint sequencer
// Turns demands, position samples and ticks into drive commands with
// backlash compensation, timeout and drift detection.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the request kind (demand, position
//   sample, tick), tdata the demand and the measured valve position.
//   Output stream m_axis: one result per position sample; demands and ticks
//   update the state only. tuser is the command-valid flag, tdata holds the
//   command, the fault code and the mode after the sample.
//   Configuration: cfg_we_i writes cfg_data_i to register cfg_idx_i
//   (backlash step, minimal move, in-position band, move time, transition
//   time); write only while the block is idle.
//   Throughput: one item per cycle while s_axis_tready is high; each item updates
//   the state registers in the cycle of its transfer. A result is registered
//   in the output register, or in the skid stage while the output is stalled.
//   Reset: registers take their default values, mode is on target, the last
//   setpoint is zero and the remaining move time is twice the move time.
//   Back-pressure: an output register with a skid stage holds up to two
//   results; s_axis_tready drops only while the skid stage is full.
// ----------------------------------------------------------------------------
`default_nettype none

module backlash_compensated_valve_sequencer_core
  import bcvs_pkg::*;
#(
  parameter int unsigned FULL_SCALE_POS = POS_FULL_SCALE
) (
  input  var logic                  clk_i,
  input  var logic                  rst_ni,
  // Input stream
  input  var logic                  s_axis_tvalid,
  output var logic                  s_axis_tready,
  input  var logic [31:0]           s_axis_tdata,  // [13:0] demand, [27:14] position
  input  var logic [1:0]            s_axis_tuser,  // [1:0] req_type
  // Output stream
  output var logic                  m_axis_tvalid,
  input  var logic                  m_axis_tready,
  output var logic [23:0]           m_axis_tdata,  // [13:0] command, [15:14] fault_code,
                                                   // [17:16] mode_now
  output var logic                  m_axis_tuser,  // [0] command_valid
  // Configuration write port
  input  var logic                  cfg_we_i,
  input  var logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  var logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  state_t  state_q, state_d;
  result_t step_res;
  logic    step_has_res;
  logic    in_xfer;
  logic    new_res;

  logic    out_valid_q;
  result_t out_data_q;
  logic    skid_valid_q;
  result_t skid_data_q;

  assign s_axis_tready = !skid_valid_q;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  bcvs_step #(
    .FULL_SCALE_POS (FULL_SCALE_POS)
  ) u_step (
    .cfg_i        (cfg_q),
    .state_i      (state_q),
    .req_type_i   (s_axis_tuser),
    .demand_i     (s_axis_tdata[13:0]),
    .meas_pos_i   (s_axis_tdata[27:14]),
    .state_o      (state_d),
    .has_result_o (step_has_res),
    .result_o     (step_res)
  );

  assign new_res = in_xfer && step_has_res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.overshoot_step   <= BACKLASH_RST;
      cfg_q.minimal_move     <= MIN_MOVE_RST;
      cfg_q.in_position      <= IN_POS_RST;
      cfg_q.move_time_ticks  <= MOVE_TIME_RST;
      cfg_q.transition_ticks <= TRANS_TIME_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_OVERSHOOT_STEP:   cfg_q.overshoot_step   <= cfg_data_i[BL_W-1:0];
        REG_MINIMAL_MOVE:     cfg_q.minimal_move     <= cfg_data_i[POS_W-1:0];
        REG_IN_POSITION:      cfg_q.in_position      <= cfg_data_i[POS_W-1:0];
        REG_MOVE_TIME_TICKS:  cfg_q.move_time_ticks  <= cfg_data_i[TICK_W-1:0];
        REG_TRANSITION_TICKS: cfg_q.transition_ticks <= cfg_data_i[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer state; advance on every input transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode            <= MODE_ON_TARGET;
      state_q.last_setpoint   <= '0;
      state_q.comp_setpoint   <= '0;
      state_q.remaining_ticks <= REM_RST;
    end else if (in_xfer) begin
      state_q.mode            <= state_d.mode;
      state_q.last_setpoint   <= state_d.last_setpoint;
      state_q.comp_setpoint   <= state_d.comp_setpoint;
      state_q.remaining_ticks <= state_d.remaining_ticks;
    end
  end

  // Output register and skid stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || m_axis_tready) begin
      out_valid_q  <= skid_valid_q || new_res;
      skid_valid_q <= 1'b0;
    end else if (new_res) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Result payload: drain the skid stage first, hold while stalled
  always_ff @(posedge clk_i) begin
    if (!out_valid_q || m_axis_tready) begin
      out_data_q <= skid_valid_q ? skid_data_q : step_res;
    end else if (new_res) begin
      skid_data_q <= step_res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_data_q.command_valid;
  assign m_axis_tdata  = {6'b0, out_data_q.mode_now, out_data_q.fault_code,
                          out_data_q.command};

endmodule

`default_nettype wire
